FILE: src/fsd_pkg.sv
// Package of shared constants, types and tables for the frequency substitution decoder.
package fsd_pkg;

	localparam int COUNT_BITS  = 16;
	localparam int NUM_LETTERS = 26;
	localparam int LIDX_W      = $clog2(NUM_LETTERS);

	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
	localparam logic [7:0] ASCII_TAB     = 8'h09;
	localparam logic [7:0] ASCII_CR      = 8'h0D;
	localparam logic [7:0] ASCII_SPACE   = 8'h20;

	localparam logic [LIDX_W-1:0] LAST_LETTER = LIDX_W'(NUM_LETTERS - 1);

	// Plaintext letters of English, most frequent first.
	localparam logic [LIDX_W-1:0] ENGLISH_ORDER [NUM_LETTERS] = '{
		5'd4,  5'd0,  5'd17, 5'd8,  5'd14, 5'd19, 5'd13, 5'd18, 5'd11,
		5'd2,  5'd20, 5'd3,  5'd15, 5'd12, 5'd7,  5'd6,  5'd1,  5'd5,
		5'd24, 5'd22, 5'd10, 5'd21, 5'd23, 5'd25, 5'd9,  5'd16
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RANK,
		ST_COMMIT
	} fsd_state_t;

	typedef struct packed {
		logic count_en;
		logic xlate_en;
		logic clear_en;
		logic rank_start;
		logic rank_step;
		logic commit;
	} fsd_cmd_t;

	typedef struct packed {
		logic rank_done;
		logic out_busy;
	} fsd_stat_t;

endpackage

FILE: src/fsd_if.sv
// Stream interfaces for the ciphertext input and the plaintext output channels.
interface fsd_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] char_in;
	logic       last;

	modport source (output valid, output func, output char_in, output last, input ready);
	modport sink   (input valid, input func, input char_in, input last, output ready);
endinterface

interface fsd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       out_last;

	modport source (output valid, output char_out, output out_last, input ready);
	modport sink   (input valid, input char_out, input out_last, output ready);
endinterface

FILE: src/fsd_ctrl.sv
// Controller state machine: input handshake, ranking sequence and map commit.
module fsd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_func,
	input  logic             in_last,
	input  fsd_pkg::fsd_stat_t stat,
	output logic             in_ready,
	output fsd_pkg::fsd_cmd_t  cmd
);

	fsd_pkg::fsd_state_t state_q, state_d;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == fsd_pkg::ST_IDLE) && !(in_func && stat.out_busy);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			fsd_pkg::ST_IDLE: begin
				if (accept && !in_func && in_last) begin
					state_d = fsd_pkg::ST_RANK;
				end
			end
			fsd_pkg::ST_RANK: begin
				if (stat.rank_done) begin
					state_d = fsd_pkg::ST_COMMIT;
				end
			end
			fsd_pkg::ST_COMMIT: begin
				state_d = fsd_pkg::ST_IDLE;
			end
			default: begin
				state_d = fsd_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			fsd_pkg::ST_IDLE: begin
				cmd.count_en   = accept && !in_func;
				cmd.xlate_en   = accept && in_func;
				cmd.clear_en   = accept && in_func && in_last;
				cmd.rank_start = accept && !in_func && in_last;
			end
			fsd_pkg::ST_RANK: begin
				cmd.rank_step = 1'b1;
			end
			fsd_pkg::ST_COMMIT: begin
				cmd.commit = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// No beat is taken while the ranking sequence runs.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != fsd_pkg::ST_IDLE) |-> !in_ready)
		else $error("input accepted during ranking");

	a_commit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> !cmd.commit && (state_q == fsd_pkg::ST_IDLE))
		else $error("commit not followed by idle");

	a_rank_then_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rank_step && stat.rank_done) |=> cmd.commit)
		else $error("ranking end not followed by commit");

endmodule

FILE: src/fsd_datapath.sv
// Datapath: letter counters, rank accumulators, substitution map and output register.
module fsd_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         char_in,
	input  logic               in_last,
	input  fsd_pkg::fsd_cmd_t  cmd,
	output fsd_pkg::fsd_stat_t stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         char_out,
	output logic               out_last
);

	logic [fsd_pkg::COUNT_BITS-1:0] counts_q [fsd_pkg::NUM_LETTERS];
	logic [fsd_pkg::LIDX_W-1:0]     rank_q   [fsd_pkg::NUM_LETTERS];
	logic [fsd_pkg::LIDX_W-1:0]     map_q    [fsd_pkg::NUM_LETTERS];
	logic [fsd_pkg::LIDX_W-1:0]     b_q;
	logic                           out_valid_q;
	logic [7:0]                     char_out_q;
	logic                           out_last_q;

	logic                           is_upper, is_lower, is_letter, is_space;
	logic [7:0]                     letter_off;
	logic [fsd_pkg::LIDX_W-1:0]     letter_idx;
	logic [fsd_pkg::COUNT_BITS-1:0] count_b;
	logic [fsd_pkg::NUM_LETTERS-1:0] beats_a;
	logic [fsd_pkg::NUM_LETTERS-1:0] count_nz;
	logic [7:0]                     xlate;

	assign is_upper  = (char_in >= fsd_pkg::ASCII_UPPER_A) && (char_in <= fsd_pkg::ASCII_UPPER_Z);
	assign is_lower  = (char_in >= fsd_pkg::ASCII_LOWER_A) && (char_in <= fsd_pkg::ASCII_LOWER_Z);
	assign is_letter = is_upper || is_lower;
	assign is_space  = (char_in inside {[fsd_pkg::ASCII_TAB:fsd_pkg::ASCII_CR],
		fsd_pkg::ASCII_SPACE});
	assign letter_off = is_upper ? (char_in - fsd_pkg::ASCII_UPPER_A)
		: (char_in - fsd_pkg::ASCII_LOWER_A);
	assign letter_idx = letter_off[fsd_pkg::LIDX_W-1:0];

	// The comparison letter b is broadcast to all 26 rank accumulators at once.
	assign count_b = counts_q[b_q];

	always_comb begin
		for (int a = 0; a < fsd_pkg::NUM_LETTERS; a++) begin
			beats_a[a] = (count_b > counts_q[a]) ||
				((count_b == counts_q[a]) && (b_q < fsd_pkg::LIDX_W'(a)));
			count_nz[a] = |counts_q[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fsd_pkg::NUM_LETTERS; i++) begin
				counts_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < fsd_pkg::NUM_LETTERS; i++) begin
				if (cmd.clear_en) begin
					counts_q[i] <= '0;
				end else if (cmd.count_en && is_letter &&
					(letter_idx == fsd_pkg::LIDX_W'(i)) && (counts_q[i] != '1)) begin
					counts_q[i] <= counts_q[i] + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < fsd_pkg::NUM_LETTERS; i++) begin
			if (cmd.rank_start) begin
				rank_q[i] <= '0;
			end else if (cmd.rank_step && beats_a[i]) begin
				rank_q[i] <= rank_q[i] + 1'b1;
			end
		end
	end

	// The comparison letter stops on the last letter so that it never leaves the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q <= '0;
		end else if (cmd.rank_start) begin
			b_q <= '0;
		end else if (cmd.rank_step && !stat.rank_done) begin
			b_q <= b_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fsd_pkg::NUM_LETTERS; i++) begin
				map_q[i] <= fsd_pkg::LIDX_W'(i);
			end
		end else if (cmd.commit) begin
			for (int i = 0; i < fsd_pkg::NUM_LETTERS; i++) begin
				map_q[i] <= fsd_pkg::ENGLISH_ORDER[rank_q[i]];
			end
		end
	end

	always_comb begin
		if (is_letter) begin
			xlate = fsd_pkg::ASCII_UPPER_A + 8'(map_q[letter_idx]);
		end else if (is_space) begin
			xlate = fsd_pkg::ASCII_SPACE;
		end else begin
			xlate = char_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.xlate_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.xlate_en) begin
			char_out_q <= xlate;
			out_last_q <= in_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign char_out       = char_out_q;
	assign out_last       = out_last_q;
	assign stat.rank_done = (b_q == fsd_pkg::LAST_LETTER);
	assign stat.out_busy  = out_valid_q && !out_ready;

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_en |=> (count_nz == '0))
		else $error("counters not cleared after last translate beat");

	a_b_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rank_step |-> (b_q <= fsd_pkg::LAST_LETTER))
		else $error("rank index out of range");

	a_xlate_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.xlate_en |=> out_valid_q)
		else $error("translate beat did not load the output register");

endmodule

FILE: src/frequency_substitution_decoder_top.sv
// Top level of the frequency substitution decoder: controller, datapath and channel ports.
//
//   Channel  Role    Beat payload
//   cipher   sink    func, char_in, last   (count or translate byte)
//   plain    source  char_out, out_last    (one beat per translate byte)
//
// Count and translate beats are taken one per cycle outside the ranking; a translate
// beat's result appears in the output register on the next cycle and a new beat is
// taken while it waits. The last count beat starts the ranking: one comparison letter a
// cycle against all 26 rank accumulators, then the map is written; cipher.ready stays low.
// Else a translate beat is held off only while a finished result stalls on plain.ready.
// arst_n clears the counters, sets the identity map and empties the output register.
module frequency_substitution_decoder_top (
	input  logic          clk,
	input  logic          arst_n,
	fsd_in_if.sink        cipher,
	fsd_out_if.source     plain
);

	fsd_pkg::fsd_cmd_t  cmd;
	fsd_pkg::fsd_stat_t stat;
	logic               in_ready;

	// The controller sees only the handshake and the pass controls; bytes go to the datapath.
	fsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cipher.valid),
		.in_func  (cipher.func),
		.in_last  (cipher.last),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	assign cipher.ready = in_ready;

	// The datapath holds all letter state and the registered output beat.
	fsd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (cipher.char_in),
		.in_last   (cipher.last),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (plain.valid),
		.out_ready (plain.ready),
		.char_out  (plain.char_out),
		.out_last  (plain.out_last)
	);

endmodule

FILE: test/tb_frequency_substitution_decoder_top.sv
// Self-checking testbench for the frequency substitution decoder top level.
`timescale 1ns / 1ps

module tb_frequency_substitution_decoder_top;
	import fsd_pkg::*;

	// Function codes carried in the func field of a cipher beat.
	typedef enum logic {
		FUNC_COUNT     = 1'b0,
		FUNC_TRANSLATE = 1'b1
	} fsd_func_t;

	// One cipher beat waiting to be sent. When drain is set, the sender holds
	// the beat back until every plaintext beat already owed has come out.
	typedef struct packed {
		fsd_func_t  func;
		logic [7:0] char_in;
		logic       last;
		logic       drain;
	} cipher_beat_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       out_last;
	} plain_beat_t;

	// Plaintext letters of English, most frequent first, kept independently of
	// the package table so that a wrong table in the design shows up.
	localparam logic [8*NUM_LETTERS-1:0] ENGLISH_BY_FREQ = "EARIOTNSLCUDPMHGBFYWKVXZJQ";

	localparam int RANDOM_BEATS   = 650;
	localparam int CALM_TAIL      = 80;
	localparam int SETTLE_CYCLES  = 60;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk;
	logic arst_n;

	fsd_in_if  cipher_ch ();
	fsd_out_if plain_ch ();

	frequency_substitution_decoder_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cipher (cipher_ch),
		.plain  (plain_ch)
	);

	// Beats still to be sent, and plaintext beats owed by the block, oldest first.
	cipher_beat_t beats_pending [$];
	plain_beat_t  plain_expected [$];
	logic [7:0]   pass_text [$];

	// The predictor's own copy of the block's state.
	logic [COUNT_BITS-1:0] letter_tally [NUM_LETTERS];
	logic [LIDX_W-1:0]     cipher_to_plain [NUM_LETTERS];

	int  mismatches;
	int  idle_cycles;
	logic in_taken;
	int  send_gap;
	int  recv_stall;
	bit  send_quiet;
	bit  recv_quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Works out what one accepted cipher beat does to the predicted state, and
	// records the plaintext beat it owes if it is a translate beat.
	task automatic decipher_beat(logic func_bit, logic [7:0] ch, logic last_bit);
		int          idx;
		int          rank;
		plain_beat_t res;
		idx = -1;
		if (ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z) begin
			idx = ch - ASCII_UPPER_A;
		end else if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z) begin
			idx = ch - ASCII_LOWER_A;
		end
		if (func_bit == FUNC_COUNT) begin
			// Counters hold at full scale rather than wrapping.
			if (idx >= 0 && letter_tally[idx] != '1) begin
				letter_tally[idx] = letter_tally[idx] + 1'b1;
			end
			// The closing count beat is counted first, then the letters are ranked.
			// A letter's rank is the number of letters that beat it: a higher count,
			// or an equal count and an earlier place in the alphabet.
			if (last_bit) begin
				for (int a = 0; a < NUM_LETTERS; a++) begin
					rank = 0;
					for (int b = 0; b < NUM_LETTERS; b++) begin
						if (letter_tally[b] > letter_tally[a] ||
						    (letter_tally[b] == letter_tally[a] && b < a)) begin
							rank++;
						end
					end
					cipher_to_plain[a] = LIDX_W'(ENGLISH_BY_FREQ[8*(NUM_LETTERS-1-rank) +: 8]
					                     - ASCII_UPPER_A);
				end
			end
		end else begin
			if (idx >= 0) begin
				res.char_out = ASCII_UPPER_A + 8'(cipher_to_plain[idx]);
			end else if (ch == ASCII_SPACE || (ch >= ASCII_TAB && ch <= ASCII_CR)) begin
				res.char_out = ASCII_SPACE;
			end else begin
				res.char_out = ch;
			end
			res.out_last = last_bit;
			plain_expected.push_back(res);
			// The closing translate beat clears the counters but keeps the map.
			if (last_bit) begin
				foreach (letter_tally[i]) letter_tally[i] = '0;
			end
		end
	endtask

	task automatic queue_beat(fsd_func_t f, logic [7:0] ch, logic last_bit, logic drain_bit);
		cipher_beat_t b;
		b.func    = f;
		b.char_in = ch;
		b.last    = last_bit;
		b.drain   = drain_bit;
		beats_pending.push_back(b);
	endtask

	// Sends the text held in pass_text as one pass, closing it with last.
	task automatic queue_pass(fsd_func_t f, logic drain_first);
		foreach (pass_text[i]) begin
			queue_beat(f, pass_text[i], i == pass_text.size() - 1, drain_first && i == 0);
		end
	endtask

	// Mostly letters of mixed case with a skewed spread, so that rankings have a
	// clear order with some ties; the key rotates which letters dominate.
	function automatic logic [7:0] random_cipher_char(int unsigned key);
		int unsigned pick;
		int unsigned letter;
		pick = $urandom_range(0, 19);
		if (pick < 14) begin
			letter = ($urandom_range(0, $urandom_range(0, NUM_LETTERS - 1)) + key) % NUM_LETTERS;
			return ($urandom_range(0, 1) ? ASCII_LOWER_A : ASCII_UPPER_A) + 8'(letter);
		end else if (pick < 17) begin
			return ($urandom_range(0, 5) == 5) ? ASCII_SPACE : ASCII_TAB + 8'($urandom_range(0, 4));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic make_text(int unsigned len, int unsigned key);
		pass_text.delete();
		repeat (len) pass_text.push_back(random_cipher_char(key));
	endtask

	// Driver: presents the next beat at the falling edge once the previous one
	// has been taken, with random bursts of idle cycles between beats.
	always @(negedge clk) begin
		cipher_beat_t nb;
		bit           calm;
		calm = beats_pending.size() < CALM_TAIL;
		if ($urandom_range(0, 49) == 0) send_quiet <= !send_quiet;
		if (arst_n && (!cipher_ch.valid || in_taken)) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				cipher_ch.valid <= 1'b0;
			end else if (beats_pending.size() != 0 &&
			             !(beats_pending[0].drain && plain_expected.size() != 0)) begin
				if (!calm && !send_quiet && $urandom_range(0, 7) == 0) begin
					send_gap <= $urandom_range(1, 19) - 1;
					cipher_ch.valid <= 1'b0;
				end else begin
					nb = beats_pending.pop_front();
					cipher_ch.func    <= nb.func;
					cipher_ch.char_in <= nb.char_in;
					cipher_ch.last    <= nb.last;
					cipher_ch.valid   <= 1'b1;
				end
			end else begin
				cipher_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure: ready drops for random bursts, none near the end.
	always @(negedge clk) begin
		bit calm;
		calm = beats_pending.size() < CALM_TAIL;
		if ($urandom_range(0, 49) == 0) recv_quiet <= !recv_quiet;
		if (arst_n) begin
			if (recv_stall != 0) begin
				recv_stall <= recv_stall - 1;
				plain_ch.ready <= 1'b0;
			end else if (!calm && !recv_quiet && $urandom_range(0, 7) == 0) begin
				recv_stall <= $urandom_range(1, 19) - 1;
				plain_ch.ready <= 1'b0;
			end else begin
				plain_ch.ready <= 1'b1;
			end
		end
	end

	// Monitor: at each rising edge, feeds accepted cipher beats to the predictor,
	// checks accepted plaintext beats against the oldest expectation, and keeps
	// the watchdog that ends a run in which nothing moves.
	always @(posedge clk) begin
		plain_beat_t want;
		bit          moved;
		if (arst_n) begin
			moved = 1'b0;
			in_taken <= cipher_ch.valid && cipher_ch.ready;
			if (cipher_ch.valid && cipher_ch.ready) begin
				moved = 1'b1;
				decipher_beat(cipher_ch.func, cipher_ch.char_in, cipher_ch.last);
			end
			if (plain_ch.valid && plain_ch.ready) begin
				moved = 1'b1;
				if (plain_expected.size() == 0) begin
					mismatches++;
					$display("%0t: plaintext beat with none expected, got char_out 8'h%02h out_last %0b",
					         $time, plain_ch.char_out, plain_ch.out_last);
				end else begin
					want = plain_expected.pop_front();
					if (plain_ch.char_out !== want.char_out) begin
						mismatches++;
						$display("%0t: char_out expected 8'h%02h, got 8'h%02h",
						         $time, want.char_out, plain_ch.char_out);
					end
					if (plain_ch.out_last !== want.out_last) begin
						mismatches++;
						$display("%0t: out_last expected %0b, got %0b",
						         $time, want.out_last, plain_ch.out_last);
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		int random_start;
		int unsigned key;
		int unsigned kind;
		arst_n            = 1'b0;
		cipher_ch.valid   = 1'b0;
		cipher_ch.func    = FUNC_COUNT;
		cipher_ch.char_in = 8'h00;
		cipher_ch.last    = 1'b0;
		plain_ch.ready    = 1'b0;
		in_taken          = 1'b0;
		mismatches        = 0;
		idle_cycles       = 0;
		send_gap          = 0;
		recv_stall        = 0;
		send_quiet        = 1'b0;
		recv_quiet        = 1'b0;
		foreach (letter_tally[i]) begin
			letter_tally[i]    = '0;
			cipher_to_plain[i] = LIDX_W'(i);
		end

		// Translate before any count: the identity map applies, so letters of
		// either case come out upper case, whitespace becomes a space, and the
		// bytes just outside the letter and whitespace ranges pass unchanged.
		pass_text = '{"a", "z", "A", "Z", ASCII_TAB, ASCII_CR, ASCII_SPACE, 8'h08, 8'h0E,
		              8'h00, 8'hFF, "@", "[", 8'h60, "{"};
		queue_pass(FUNC_TRANSLATE, 1'b1);

		// A short count pass with a tie between a and q, which a must win, and
		// most letters never seen, which rank by alphabet at a count of zero.
		pass_text = '{"b", "B", "q", "a"};
		queue_pass(FUNC_COUNT, 1'b0);
		pass_text = '{"a", "b", "Q", "z", "c"};
		queue_pass(FUNC_TRANSLATE, 1'b1);

		// A count pass of e alone: e takes the top rank and every other letter
		// falls in behind it in alphabetical order.
		repeat (2) queue_beat(FUNC_COUNT, "e", 1'b0, 1'b0);
		queue_beat(FUNC_COUNT, "E", 1'b1, 1'b0);
		pass_text.delete();
		for (int i = 0; i < NUM_LETTERS; i++) pass_text.push_back(ASCII_UPPER_A + 8'(i));
		queue_pass(FUNC_TRANSLATE, 1'b1);

		// Random part: mostly a count pass followed by a translate pass, with
		// counts that build over two passes, lone passes of either kind, and
		// some beats with every field random.
		random_start = beats_pending.size();
		while (beats_pending.size() < random_start + RANDOM_BEATS) begin
			key  = $urandom_range(0, NUM_LETTERS - 1);
			kind = $urandom_range(0, 9);
			make_text($urandom_range(1, 40), key);
			if (kind < 7) begin
				queue_pass(FUNC_COUNT, 1'b0);
				if (kind == 0) begin
					make_text($urandom_range(1, 40), key);
					queue_pass(FUNC_COUNT, 1'b0);
				end
				if (kind[0]) make_text($urandom_range(1, 40), key);
				queue_pass(FUNC_TRANSLATE, $urandom_range(0, 3) == 0);
			end else if (kind == 7) begin
				queue_pass(FUNC_TRANSLATE, 1'b0);
			end else if (kind == 8) begin
				queue_pass(FUNC_COUNT, 1'b0);
			end else begin
				repeat ($urandom_range(1, 10)) begin
					queue_beat(fsd_func_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					           $urandom_range(0, 3) == 0, 1'b0);
				end
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every beat has been taken and every result has come, then
		// give a ranking that may still be running time to show stray output.
		wait (beats_pending.size() == 0 && !cipher_ch.valid);
		wait (plain_expected.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && plain_expected.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
